// ----- rtl/extended_delay_timer_assert.svh -----
// Assertion macros used by the checker file.
`ifndef EXTENDED_DELAY_TIMER_ASSERT_SVH
`define EXTENDED_DELAY_TIMER_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define EDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication under an active-low reset.
`define EDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/edt_pkg.sv -----
`timescale 1ns / 1ps

package edt_pkg;

  localparam int unsigned CLOCK_MHZ    = 8;
  localparam int unsigned MAX_DELAY_MS = 4294967;
  localparam int unsigned MS_TO_US     = 1000;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned DELAY_W  = 23;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned CNT_W    = $clog2(PROD_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // Largest tick time is 2^3 * 4 / CLOCK_MHZ microseconds.
  localparam int unsigned TICK_MAX = 32 / CLOCK_MHZ;
  localparam int unsigned TICK_W   = (TICK_MAX < 2) ? 1 : $clog2(TICK_MAX + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER = CFG_IDX_W'(1);

  localparam logic MODE_TIMER   = 1'b0;
  localparam logic MODE_COUNTER = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK          = 3'd0,
    ACT_START_TIMER   = 3'd1,
    ACT_START_COUNTER = 3'd2,
    ACT_WRITE_COUNT   = 3'd3,
    ACT_READ_COUNT    = 3'd4,
    ACT_STOP          = 3'd5
  } action_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic finish;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [TICK_W-1:0] tick_us(input logic [1:0] prescaler);
    int unsigned num;
    num = (32'd1 << prescaler) * 32'd4;
    return TICK_W'(num / CLOCK_MHZ);
  endfunction

endpackage

// ----- rtl/edt_ctrl.sv -----
`timescale 1ns / 1ps

module edt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  edt_pkg::dp_status_t    status_i,
  output edt_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.need_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/edt_datapath.sv -----
`timescale 1ns / 1ps

module edt_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [edt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [edt_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [edt_pkg::ACTION_W-1:0]          action_i,
  input  logic [edt_pkg::DELAY_W-1:0]           wait_ms_i,
  input  logic [edt_pkg::COUNT_W-1:0]           counter_value_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic                                  status_o,
  output logic [edt_pkg::COUNT_W-1:0]           read_value_o,
  output logic                                  fired_o,
  input  edt_pkg::ctrl_cmd_t                    cmd_i,
  output edt_pkg::dp_status_t                   status_dp_o
);

  localparam int unsigned CW = edt_pkg::COUNT_W;
  localparam int unsigned PW = edt_pkg::PROD_W;
  localparam int unsigned TW = edt_pkg::TICK_W;

  logic                        mode_q, mode_d;
  logic [1:0]                  prescaler_q, prescaler_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               wraps_q, wraps_d;
  logic [CW-1:0]               needed_q, needed_d;
  logic [CW-1:0]               reload_q, reload_d;
  logic                        running_q, running_d;
  logic [TW-1:0]               rem_q, rem_d;
  logic [PW-1:0]               quo_q, quo_d;
  logic [TW-1:0]               divisor_q, divisor_d;
  logic [edt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        res_status_q, res_status_d;
  logic [CW-1:0]               res_rd_q, res_rd_d;
  logic                        res_fired_q, res_fired_d;
  logic                        out_valid_q;
  logic                        out_status_q;
  logic [CW-1:0]               out_rd_q;
  logic                        out_fired_q;

  edt_pkg::action_e            act;
  logic [TW-1:0]               tick;
  logic [edt_pkg::DELAY_W-1:0] delay_sat;
  logic [PW-1:0]               product;
  logic [CW-1:0]               tick_inc;
  logic [CW-1:0]               wraps_inc;
  logic [TW:0]                 shifted;
  logic [TW:0]                 trial;
  logic [CW:0]                 need_wide;

  assign act       = edt_pkg::action_e'(action_i);
  assign tick      = edt_pkg::tick_us(prescaler_q);
  assign delay_sat = (wait_ms_i > edt_pkg::DELAY_W'(edt_pkg::MAX_DELAY_MS))
                   ? edt_pkg::DELAY_W'(edt_pkg::MAX_DELAY_MS) : wait_ms_i;
  assign product   = PW'(delay_sat) * PW'(edt_pkg::MS_TO_US);
  assign tick_inc  = count_q + CW'(1);
  assign wraps_inc = wraps_q + CW'(1);
  assign shifted   = {rem_q, quo_q[PW-1]};
  assign trial     = shifted - {1'b0, divisor_q};
  assign need_wide = {1'b0, quo_q[PW-1:CW]} + (CW+1)'(quo_q[CW-1:0] != '0);

  assign status_dp_o.need_div = (act == edt_pkg::ACT_START_TIMER)
                              && (mode_q == edt_pkg::MODE_TIMER) && (tick != '0);
  assign status_dp_o.div_last = (cnt_q == '0);
  assign status_dp_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    mode_d      = mode_q;
    prescaler_d = prescaler_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        edt_pkg::CFG_MODE:      mode_d      = cfg_data_i[0];
        edt_pkg::CFG_PRESCALER: prescaler_d = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d      = count_q;
    wraps_d      = wraps_q;
    needed_d     = needed_q;
    reload_d     = reload_q;
    running_d    = running_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    divisor_d    = divisor_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    res_fired_d  = res_fired_q;

    if (cmd_i.load) begin
      res_status_d = 1'b0;
      res_rd_d     = '0;
      res_fired_d  = 1'b0;
      case (act)
        edt_pkg::ACT_TICK: begin
          if (running_q) begin
            count_d = tick_inc;
            if (tick_inc == '0) begin
              wraps_d = wraps_inc;
              if ((needed_q == '0) || (wraps_inc >= needed_q)) begin
                count_d     = reload_q + CW'(2);
                wraps_d     = '0;
                res_fired_d = 1'b1;
              end
            end
          end
        end
        edt_pkg::ACT_START_TIMER: begin
          if (!status_dp_o.need_div) begin
            res_status_d = 1'b1;
          end else begin
            rem_d     = '0;
            quo_d     = product;
            divisor_d = tick;
            cnt_d     = edt_pkg::CNT_W'(PW - 1);
          end
        end
        edt_pkg::ACT_START_COUNTER: begin
          if (mode_q != edt_pkg::MODE_COUNTER) begin
            res_status_d = 1'b1;
          end else begin
            wraps_d   = '0;
            running_d = 1'b1;
          end
        end
        edt_pkg::ACT_WRITE_COUNT: begin
          count_d = counter_value_i + CW'(2);
        end
        edt_pkg::ACT_READ_COUNT: begin
          res_rd_d = count_q;
        end
        edt_pkg::ACT_STOP: begin
          running_d = 1'b0;
        end
        default: begin
          res_status_d = 1'b1;
        end
      endcase
    end

    if (cmd_i.div_step) begin
      if (!trial[TW]) begin
        rem_d = trial[TW-1:0];
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = shifted[TW-1:0];
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - edt_pkg::CNT_W'(1);
    end

    if (cmd_i.finish) begin
      needed_d     = need_wide[CW] ? '1 : need_wide[CW-1:0];
      reload_d     = CW'(0) - quo_q[CW-1:0];
      count_d      = (CW'(0) - quo_q[CW-1:0]) + CW'(2);
      wraps_d      = '0;
      running_d    = 1'b1;
      res_status_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= edt_pkg::MODE_TIMER;
      prescaler_q <= '0;
      count_q     <= '0;
      wraps_q     <= '0;
      needed_q    <= '0;
      reload_q    <= '0;
      running_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      prescaler_q <= prescaler_d;
      count_q     <= count_d;
      wraps_q     <= wraps_d;
      needed_q    <= needed_d;
      reload_q    <= reload_d;
      running_q   <= running_d;
      cnt_q       <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    divisor_q    <= divisor_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    res_fired_q  <= res_fired_d;
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_rd_q     <= res_rd_q;
      out_fired_q  <= res_fired_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_rd_q;
  assign fired_o      = out_fired_q;

endmodule

// ----- rtl/extended_delay_timer.sv -----
`timescale 1ns / 1ps

// 16-bit preloaded up-counter that stretches one delay over many overflows.
// Each item gives exactly one result, and the input is stalled until it is
// emitted. Tick, write, read, stop, start counter, unknown and rejected items
// register their result at acceptance and then move it into the output
// register. A start timer item in timer mode with a nonzero tick time runs,
// between acceptance and emit, the one-bit-per-cycle divider that turns the
// delay in microseconds into timer ticks and then a step that derives the
// overflow count and preload. While the output register still waits to be
// taken the result cannot move in, and the input stays stalled for as long
// as that wait lasts; the next item is accepted once the current one sits in
// the output register.
// Configuration registers (mode at index 0, prescaler at index 1) are always
// ready and are meant to be written while no item is in flight.
module extended_delay_timer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [edt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [edt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [edt_pkg::ACTION_W-1:0]       action_i,
  input  logic [edt_pkg::DELAY_W-1:0]        wait_ms_i,
  input  logic [edt_pkg::COUNT_W-1:0]        counter_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               status_o,
  output logic [edt_pkg::COUNT_W-1:0]        read_value_o,
  output logic                               fired_o
);

  edt_pkg::ctrl_cmd_t  cmd;
  edt_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  edt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  edt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .wait_ms_i       (wait_ms_i),
    .counter_value_i (counter_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .fired_o         (fired_o),
    .cmd_i           (cmd),
    .status_dp_o     (dp_status)
  );

endmodule

// ----- rtl/edt_checker.sv -----
`timescale 1ns / 1ps

`include "extended_delay_timer_assert.svh"

module edt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           status_o,
  input logic [edt_pkg::COUNT_W-1:0]    read_value_o,
  input logic                           fired_o
);

  `EDT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `EDT_ASSERT_IMPLY(a_fire_not_rejected, clk_i, rst_ni, out_valid_o && fired_o, !status_o)
  `EDT_ASSERT_IMPLY(a_read_not_fired, clk_i, rst_ni, out_valid_o && (read_value_o != '0), !fired_o && !status_o)
  `EDT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_value_o))

endmodule

bind extended_delay_timer edt_checker u_edt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .read_value_o (read_value_o),
  .fired_o      (fired_o)
);

// ----- sim/extended_delay_timer_test.sv -----
`timescale 1ns / 1ps

module extended_delay_timer_test;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 235;
  localparam int unsigned PRINT_LIMIT   = 30;

  localparam logic [edt_pkg::ACTION_W-1:0]  ACT_UNDEF_A = 3'd6;
  localparam logic [edt_pkg::ACTION_W-1:0]  ACT_UNDEF_B = 3'd7;
  localparam logic [edt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [edt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [edt_pkg::ACTION_W-1:0] action;
    logic [edt_pkg::DELAY_W-1:0]  wait_ms;
    logic [edt_pkg::COUNT_W-1:0]  counter_value;
  } timer_cmd_t;

  typedef struct packed {
    logic                        status;
    logic [edt_pkg::COUNT_W-1:0] read_value;
    logic                        fired;
  } timer_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [edt_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [edt_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [edt_pkg::ACTION_W-1:0]   action_i = '0;
  logic [edt_pkg::DELAY_W-1:0]    wait_ms_i = '0;
  logic [edt_pkg::COUNT_W-1:0]    counter_value_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           status_o;
  logic [edt_pkg::COUNT_W-1:0]    read_value_o;
  logic                           fired_o;

  extended_delay_timer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .wait_ms_i       (wait_ms_i),
    .counter_value_i (counter_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .fired_o         (fired_o)
  );

  // Predicted block state and configuration.
  logic                        mode_reg = edt_pkg::MODE_TIMER;
  logic [1:0]                  prescale_reg = '0;
  logic [edt_pkg::COUNT_W-1:0] timer_count = '0;
  logic [edt_pkg::COUNT_W-1:0] overflow_seen = '0;
  logic [edt_pkg::COUNT_W-1:0] overflow_needed = '0;
  logic [edt_pkg::COUNT_W-1:0] preload = '0;
  logic                        timer_running = 1'b0;

  timer_cmd_t    pending_cmds[$];
  timer_result_t expected_results[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned expirations_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned settings_run = 0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  bit          in_taken = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic timer_result_t predict_timer_result(input timer_cmd_t cmd);
    timer_result_t res;
    logic [31:0]   tick_len;
    logic [31:0]   dly;
    logic [31:0]   total;
    logic [31:0]   wraps_req;
    logic [31:0]   rem;
    res = '0;
    case (cmd.action)
      edt_pkg::ACT_TICK: begin
        if (timer_running) begin
          timer_count = timer_count + 16'd1;
          if (timer_count == '0) begin
            overflow_seen = overflow_seen + 16'd1;
            if (overflow_needed == '0 || overflow_seen >= overflow_needed) begin
              timer_count   = preload + 16'd2;
              overflow_seen = '0;
              res.fired     = 1'b1;
            end
          end
        end
      end
      edt_pkg::ACT_START_TIMER: begin
        tick_len = ((32'd1 << prescale_reg) * 32'd4) / edt_pkg::CLOCK_MHZ;
        if (mode_reg != edt_pkg::MODE_TIMER || tick_len == '0) begin
          res.status = 1'b1;
        end else begin
          dly = (cmd.wait_ms > edt_pkg::MAX_DELAY_MS) ? edt_pkg::MAX_DELAY_MS
              : 32'(cmd.wait_ms);
          total = (dly * edt_pkg::MS_TO_US) / tick_len;
          wraps_req = total >> edt_pkg::COUNT_W;
          rem = total & 32'h0000_FFFF;
          if (rem != '0) wraps_req = wraps_req + 32'd1;
          if (wraps_req > 32'h0000_FFFF) wraps_req = 32'h0000_FFFF;
          overflow_needed = wraps_req[edt_pkg::COUNT_W-1:0];
          preload         = 16'(32'h0001_0000 - rem);
          timer_count     = preload + 16'd2;
          overflow_seen   = '0;
          timer_running   = 1'b1;
        end
      end
      edt_pkg::ACT_START_COUNTER: begin
        if (mode_reg != edt_pkg::MODE_COUNTER) begin
          res.status = 1'b1;
        end else begin
          overflow_seen = '0;
          timer_running = 1'b1;
        end
      end
      edt_pkg::ACT_WRITE_COUNT: timer_count = cmd.counter_value + 16'd2;
      edt_pkg::ACT_READ_COUNT:  res.read_value = timer_count;
      edt_pkg::ACT_STOP:        timer_running = 1'b0;
      default:                  res.status = 1'b1;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Check results, then record the item taken at this edge.
  always @(posedge clk_i) begin
    timer_result_t want;
    timer_cmd_t    cmd;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end else begin
      in_taken = rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {status_o, read_value_o, fired_o}, '0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.fired) expirations_seen++;
          if (want.status) rejects_seen++;
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (fired_o !== want.fired) report_mismatch("fired", fired_o, want.fired);
        end
      end
      if (in_taken) begin
        cmd.action        = action_i;
        cmd.wait_ms       = wait_ms_i;
        cmd.counter_value = counter_value_i;
        expected_results.push_back(predict_timer_result(cmd));
        items_taken++;
      end
    end
  end

  // Present items and stall the result side.
  always @(negedge clk_i) begin
    timer_cmd_t cmd;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          cmd = pending_cmds.pop_front();
          in_valid_i      <= 1'b1;
          action_i        <= cmd.action;
          wait_ms_i       <= cmd.wait_ms;
          counter_value_i <= cmd.counter_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic push_cmd(input logic [edt_pkg::ACTION_W-1:0] act,
                          input logic [edt_pkg::DELAY_W-1:0] dly,
                          input logic [edt_pkg::COUNT_W-1:0] val);
    timer_cmd_t cmd;
    cmd.action        = act;
    cmd.wait_ms       = dly;
    cmd.counter_value = val;
    pending_cmds.push_back(cmd);
    items_queued++;
  endtask

  task automatic push_plain(input logic [edt_pkg::ACTION_W-1:0] act);
    push_cmd(act, 23'($urandom), 16'($urandom));
  endtask

  task automatic write_cfg(input logic [edt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [edt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == edt_pkg::CFG_MODE) mode_reg = data[0];
    else if (idx == edt_pkg::CFG_PRESCALER) prescale_reg = data[1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_empty();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic drain();
    wait_empty();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Load the counter just below the top and tick through the wrap.
  task automatic add_wrap_run();
    int unsigned gap;
    gap = $urandom_range(0, 6);
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'hFFFD - 16'(gap));
    repeat (gap + 1) push_plain(edt_pkg::ACT_TICK);
    repeat ($urandom_range(0, 2)) push_plain(edt_pkg::ACT_TICK);
    if ($urandom_range(0, 2) == 0) push_plain(edt_pkg::ACT_READ_COUNT);
  endtask

  task automatic add_timer_run();
    int unsigned                 pick;
    logic [edt_pkg::DELAY_W-1:0] dly;
    pick = $urandom_range(0, 9);
    if (pick < 5) dly = 23'($urandom_range(0, 140));
    else if (pick < 7) dly = 23'(8192 * $urandom_range(1, 4));
    else if (pick < 8) dly = 23'($urandom);
    else dly = 23'($urandom_range(4294900, 8388607));
    push_cmd(edt_pkg::ACT_START_TIMER, dly, 16'($urandom));
    repeat ($urandom_range(1, 4)) add_wrap_run();
    if ($urandom_range(0, 3) == 0) begin
      push_plain(edt_pkg::ACT_STOP);
      push_plain(edt_pkg::ACT_TICK);
      push_plain(edt_pkg::ACT_READ_COUNT);
      if ($urandom_range(0, 1) == 0) push_plain(edt_pkg::ACT_START_COUNTER);
    end
  endtask

  task automatic add_counter_run();
    push_plain(edt_pkg::ACT_START_COUNTER);
    repeat ($urandom_range(1, 4)) add_wrap_run();
    if ($urandom_range(0, 3) == 0) begin
      push_plain(edt_pkg::ACT_START_TIMER);
      push_plain(edt_pkg::ACT_STOP);
      push_plain(edt_pkg::ACT_TICK);
      push_plain(edt_pkg::ACT_READ_COUNT);
    end
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned first;
    first = items_queued;
    while (items_queued - first < n) begin
      if ($urandom_range(0, 99) < 20) push_plain(3'($urandom_range(0, 7)));
      else if (mode_reg == edt_pkg::MODE_COUNTER) add_counter_run();
      else add_timer_run();
    end
  endtask

  task automatic run_phase(input logic [edt_pkg::CFG_DATA_W-1:0] mode_data,
                           input logic [edt_pkg::CFG_DATA_W-1:0] presc,
                           input int unsigned send, input int unsigned stall,
                           input bit pause, input bit spare);
    write_cfg(edt_pkg::CFG_MODE, mode_data);
    write_cfg(edt_pkg::CFG_PRESCALER, presc);
    if (spare) begin
      write_cfg(CFG_SPARE_A, 2'($urandom));
      write_cfg(CFG_SPARE_B, 2'($urandom));
    end
    send_pct  = send;
    stall_pct = stall;
    settings_run++;
    if (pause) begin
      fill_random(PHASE_ITEMS / 2);
      wait_empty();
      fill_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    end else begin
      fill_random(PHASE_ITEMS);
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero tick time, timer mode.
    push_plain(edt_pkg::ACT_TICK);
    push_cmd(edt_pkg::ACT_START_TIMER, 23'd5, 16'($urandom));
    push_plain(edt_pkg::ACT_START_COUNTER);
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'hFFFF);
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'h0000);
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_plain(edt_pkg::ACT_STOP);
    push_plain(ACT_UNDEF_A);
    push_plain(ACT_UNDEF_B);
    push_plain(edt_pkg::ACT_READ_COUNT);
    drain();

    write_cfg(edt_pkg::CFG_MODE, 2'(edt_pkg::MODE_TIMER));
    write_cfg(edt_pkg::CFG_PRESCALER, 2'd1);
    push_cmd(edt_pkg::ACT_START_TIMER, 23'd0, 16'($urandom));
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'hFFFD);
    push_plain(edt_pkg::ACT_TICK);
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_cmd(edt_pkg::ACT_START_TIMER, 23'h7FFFFF, 16'($urandom));
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_cmd(edt_pkg::ACT_START_TIMER, 23'd65536, 16'($urandom));
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'hFFFE);
    push_plain(edt_pkg::ACT_TICK);
    push_plain(edt_pkg::ACT_READ_COUNT);
    drain();

    write_cfg(edt_pkg::CFG_MODE, 2'(edt_pkg::MODE_COUNTER));
    push_plain(edt_pkg::ACT_START_COUNTER);
    push_cmd(edt_pkg::ACT_WRITE_COUNT, 23'($urandom), 16'hFFFD);
    push_plain(edt_pkg::ACT_TICK);
    push_plain(edt_pkg::ACT_READ_COUNT);
    push_plain(edt_pkg::ACT_START_TIMER);
    drain();

    run_phase(2'd0, 2'd1, 0, 0, 1'b0, 1'b0);
    run_phase(2'd2, 2'd3, 79, 0, 1'b0, 1'b0);
    run_phase(2'd0, 2'd0, 0, 79, 1'b0, 1'b0);
    run_phase(2'd1, 2'd2, 13, 13, 1'b0, 1'b0);
    run_phase(2'd0, 2'd2, 0, 0, 1'b1, 1'b0);
    run_phase(2'd3, 2'd0, 79, 0, 1'b0, 1'b1);
    run_phase(2'd0, 2'd1, 0, 79, 1'b0, 1'b0);
    run_phase(2'd0, 2'd3, 13, 13, 1'b0, 1'b0);

    $display("covered %0d items and %0d results over %0d random settings plus directed cases",
             items_taken, results_checked, settings_run);
    $display("saw %0d delay expirations and %0d rejected items, %0d mismatches",
             expirations_seen, rejects_seen, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
